// ===== src/fbf41_pkg.sv =====
// Package for the 41-tap band-pass FIR: item structs, cell control and widths.
// Also holds the coefficient table and its conversion to signed fixed point.
// Depends on nothing; every other file in src imports it.
package fbf41_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int TAPS_DEF       = 41;
    localparam int COEF_FRAC_DEF  = 17;
    localparam int BASE_TAPS      = 41;
    localparam int HALF_BASE      = 21;

    // Half of the symmetric set, in units of 1e-9; the middle tap is the last entry.
    localparam longint COEF_NANO [HALF_BASE] = '{
        -64'sd2056037,   64'sd924852,     -64'sd1163920,   64'sd4113509,    64'sd1553636,
        64'sd3690527,    64'sd2282456,    -64'sd10000161,  -64'sd456886,    -64'sd26071766,
        64'sd7272336,    -64'sd10216734,  64'sd27880677,   64'sd39142416,   64'sd10970782,
        64'sd60208140,   -64'sd101972141, 64'sd6518833,    -64'sd269375890, -64'sd67515217,
        64'sd647999482
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          first_of_record;
    } feed_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered;
        logic                          clipped;
    } result_item_t;

    typedef struct packed {
        logic advance;  // a sample is transferred in this cycle
        logic clear;    // drop the partial sums from earlier samples
    } cell_ctrl_t;

    // Nearest integer to h[k] * 2^frac, ties away from zero; zero beyond the base set.
    function automatic longint coef_fixed(input int k, input int frac);
        int     idx;
        longint nano;
        longint mag;
        longint q;
        if (k >= BASE_TAPS) begin
            return 64'sd0;
        end
        idx  = (k < HALF_BASE) ? k : (BASE_TAPS - 1 - k);
        nano = COEF_NANO[idx];
        mag  = (nano < 0) ? -nano : nano;
        q    = ((mag <<< frac) + 64'sd500000000) / 64'sd1000000000;
        return (nano < 0) ? -q : q;
    endfunction

endpackage

// ===== src/fbf41_cell.sv =====
// One tap cell of the transposed FIR chain: constant-coefficient multiply and add.
// Holds the partial sum handed to its left neighbor. Uses fbf41_pkg.
module fbf41_cell
    import fbf41_pkg::*;
#(
    parameter int     COEF_W = COEF_FRAC_DEF + 1,
    parameter int     ACC_W  = SAMPLE_BITS + COEF_FRAC_DEF + 2,
    parameter longint COEF   = 0
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cell_ctrl_t                    ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [ACC_W-1:0]       sum_in,
    output logic signed [ACC_W-1:0]       sum_out
);

    localparam int PROD_W = SAMPLE_BITS + COEF_W;
    localparam logic signed [COEF_W-1:0] COEF_V = COEF_W'(COEF);

    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  sum_reg;
    logic signed [ACC_W-1:0]  sum_next;

    assign prod     = sample * COEF_V;
    // On a new record the right neighbor's sum holds only old samples: drop it.
    assign sum_next = ACC_W'(prod) + (ctrl.clear ? ACC_W'(0) : sum_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum_out = sum_reg;

endmodule

// ===== src/fbf41_out.sv =====
// Output stage: round the full-precision sum to sample scale, saturate, register.
// Uses fbf41_pkg for the result struct and sample width.
module fbf41_out
    import fbf41_pkg::*;
#(
    parameter int ACC_W = SAMPLE_BITS + COEF_FRAC_DEF + 2,
    parameter int FRAC  = COEF_FRAC_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  logic                    stall,
    input  logic signed [ACC_W-1:0] acc,
    output logic                    valid,
    output result_item_t            item
);

    localparam int RW = ACC_W - FRAC;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC - 1);
    localparam logic signed [RW-1:0]    MAXV = RW'((1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RW-1:0]    MINV = ~MAXV;

    logic signed [ACC_W-1:0] biased;
    logic signed [RW-1:0]    rounded;
    result_item_t            res_next;
    result_item_t            res_reg;
    logic                    valid_reg;

    assign biased  = acc + HALF;
    assign rounded = biased[ACC_W-1:FRAC];

    always_comb
    begin
        priority if (rounded > MAXV)
        begin
            res_next.filtered = MAXV[SAMPLE_BITS-1:0];
            res_next.clipped  = 1'b1;
        end
        else if (rounded < MINV)
        begin
            res_next.filtered = MINV[SAMPLE_BITS-1:0];
            res_next.clipped  = 1'b1;
        end
        else
        begin
            res_next.filtered = rounded[SAMPLE_BITS-1:0];
            res_next.clipped  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign valid = valid_reg;
    assign item  = res_reg;

endmodule

// ===== src/fixed_bandpass_fir_41.sv =====
// A transferred sample's full sum is registered in cell 0, then rounded, saturated and
// registered in the result stage, from which it is offered on the result port.
// Throughput: one sample per cycle while the output is not stalled, set by the tap
// cells updating in parallel. Reset (rst_n low, asynchronous) zeroes every partial sum,
// i.e. silent history, and empties the sum and result stages.
module fixed_bandpass_fir_41
    import fbf41_pkg::*;
#(
    parameter int TAPS           = TAPS_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         feed_valid,
    output logic         feed_stall,
    input  feed_item_t   feed,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result
);

    // Coefficients stay below one in magnitude: one sign bit over the fraction.
    // The sum of |h| is under two, so two guard bits over sample plus fraction suffice.
    localparam int COEF_W = COEF_FRAC_BITS + 1;
    localparam int ACC_W  = SAMPLE_BITS + COEF_FRAC_BITS + 2;

    // psum[k] is the partial sum held by cell k; psum[TAPS] feeds the last cell.
    // psum[0] is the complete sum for the newest transferred sample.
    logic signed [ACC_W-1:0] psum [TAPS+1];

    cell_ctrl_t ctrl;
    logic       feed_xfer;
    logic       sum_valid_reg;
    logic       sum_valid_next;
    logic       sum_move;

    // The sum in cell 0 moves on when the result register is empty or draining.
    assign sum_move  = sum_valid_reg && (!result_valid || !result_stall);
    // Hold off new samples only while a finished sum cannot move on.
    assign feed_stall = sum_valid_reg && !sum_move;
    assign feed_xfer  = feed_valid && !feed_stall;

    assign ctrl.advance = feed_xfer;
    assign ctrl.clear   = feed.first_of_record;

    assign psum[TAPS] = '0;

    // Transposed form: each cell adds its tap product to its right neighbor's sum.
    for (genvar k = 0; k < TAPS; k++)
    begin : g_tap
        fbf41_cell #(
            .COEF_W (COEF_W),
            .ACC_W  (ACC_W),
            .COEF   (coef_fixed(k, COEF_FRAC_BITS))
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .sample  (feed.sample),
            .sum_in  (psum[k+1]),
            .sum_out (psum[k])
        );
    end

    always_comb
    begin
        priority if (feed_xfer)
        begin
            sum_valid_next = 1'b1;
        end
        else if (sum_move)
        begin
            sum_valid_next = 1'b0;
        end
        else
        begin
            sum_valid_next = sum_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg <= sum_valid_next;
        end
    end

    fbf41_out #(
        .ACC_W (ACC_W),
        .FRAC  (COEF_FRAC_BITS)
    ) u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (sum_move),
        .stall (result_stall),
        .acc   (psum[0]),
        .valid (result_valid),
        .item  (result)
    );

    // A transfer always leaves a finished sum in cell 0.
    a_xfer_fills_sum: assert property (@(posedge clk) disable iff (!rst_n)
        feed_xfer |=> sum_valid_reg)
        else $error("transfer did not mark the sum stage full");

    // A waiting sum with an empty result register reaches the output next cycle.
    a_sum_drains: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid_reg && !result_valid |=> result_valid)
        else $error("sum stage did not drain into an empty result register");

    // Input is held off only when both stages are full and the output is stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        feed_stall |-> sum_valid_reg && result_valid && result_stall)
        else $error("input stalled without a blocked output");

    // A new record with a zero sample leaves the chain silent.
    a_record_clears: assert property (@(posedge clk) disable iff (!rst_n)
        feed_xfer && feed.first_of_record && feed.sample == '0
        |=> psum[0] == '0 && psum[1] == '0)
        else $error("first-of-record did not clear the history");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for the 41-tap band-pass FIR: a queue-fed driver, a stall
// generator and a monitor that checks each result against a bit-true predictor.
// Depends on fbf41_pkg for the item structs and on the fixed_bandpass_fir_41 top level.
module testbench;
    import fbf41_pkg::*;

    localparam int     TAP_COUNT      = 41;
    localparam int     PAST_DEPTH     = TAP_COUNT - 1;
    localparam int     FRAC           = 17;
    localparam longint OUT_MAX        = 64'sd32767;
    localparam longint OUT_MIN        = -64'sd32768;
    localparam int     RANDOM_ITEMS   = 2000;
    localparam int     HOLDOFF_START  = 1500;     // cycle after reset of the long hold-off
    localparam int     HOLDOFF_CYCLES = 400;
    localparam int     DRAIN_SLACK    = 16;       // pipeline is two deep; leave margin
    localparam int     RUN_LIMIT      = 5000000;  // time units, far above the slowest run
    localparam int     REPORT_LINES   = 40;

    // Half of the symmetric band-pass set in units of 1e-9, middle tap last.
    localparam longint BAND_NANO [21] = '{
        -64'sd2056037,   64'sd924852,     -64'sd1163920,   64'sd4113509,    64'sd1553636,
        64'sd3690527,    64'sd2282456,    -64'sd10000161,  -64'sd456886,    -64'sd26071766,
        64'sd7272336,    -64'sd10216734,  64'sd27880677,   64'sd39142416,   64'sd10970782,
        64'sd60208140,   -64'sd101972141, 64'sd6518833,    -64'sd269375890, -64'sd67515217,
        64'sd647999482
    };

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    // One queued sample; drain_first makes the driver wait for an empty pipeline.
    typedef struct {
        feed_item_t item;
        bit         drain_first;
    } backlog_entry_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         feed_valid = 1'b0;
    logic         feed_stall;
    feed_item_t   feed = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_item_t result;

    backlog_entry_t sample_backlog [$];
    result_item_t   filtered_due [$];

    // Predictor state: fixed-point taps and the past samples, newest first.
    longint            tap_coef [TAP_COUNT];
    logic signed [15:0] past_samples [PAST_DEPTH];

    int mismatch_count = 0;
    int results_seen   = 0;

    fixed_bandpass_fir_41 i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .feed_valid   (feed_valid),
        .feed_stall   (feed_stall),
        .feed         (feed),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Hold reset low from time zero, then release it for good.
    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Abort a hung run.
    initial begin
        #(RUN_LIMIT);
        $display("[fixed_bandpass_fir_41] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES)
            $display("mismatch in %s at result %0d: got %0d, expected %0d",
                     what, results_seen, got, want);
    endtask

    // Advance the predictor by one sample and return the filtered output it implies.
    function automatic result_item_t bandpass_predict(input feed_item_t it);
        result_item_t r;
        longint       acc;
        longint       y;
        int           k;
        if (it.first_of_record) begin
            for (k = 0; k < PAST_DEPTH; k++)
                past_samples[k] = '0;
        end
        acc = tap_coef[0] * longint'($signed(it.sample));
        for (k = 1; k < TAP_COUNT; k++)
            acc += tap_coef[k] * longint'(past_samples[k-1]);
        // add one half and floor: ties round toward plus infinity
        y = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        r.clipped = 1'b0;
        if (y > OUT_MAX) begin
            y         = OUT_MAX;
            r.clipped = 1'b1;
        end
        else if (y < OUT_MIN) begin
            y         = OUT_MIN;
            r.clipped = 1'b1;
        end
        r.filtered = y[15:0];
        for (k = PAST_DEPTH - 1; k > 0; k--)
            past_samples[k] = past_samples[k-1];
        past_samples[0] = it.sample;
        return r;
    endfunction

    task automatic queue_sample(input longint value, input bit first, input bit drain);
        backlog_entry_t e;
        e.item.sample          = value[15:0];
        e.item.first_of_record = first;
        e.drain_first          = drain;
        sample_backlog.push_back(e);
    endtask

    // Build the taps, then fill the backlog: directed cases first, random records after.
    initial begin : stimulus
        int     k;
        int     idx;
        int     i;
        int     len;
        int     kind;
        int     produced;
        int     half_period;
        bit     tie_found;
        bit     drain_done;
        bit     first;
        longint nano;
        longint mag;
        longint a;
        longint b;
        longint tie_a;
        longint tie_b;
        longint amp;
        longint polarity;
        longint value;

        for (k = 0; k < TAP_COUNT; k++) begin
            idx  = (k < 21) ? k : (TAP_COUNT - 1 - k);
            nano = BAND_NANO[idx];
            mag  = (nano < 0) ? -nano : nano;
            mag  = ((mag <<< FRAC) + 64'sd500000000) / 64'sd1000000000;
            tap_coef[k] = (nano < 0) ? -mag : mag;
        end
        for (k = 0; k < PAST_DEPTH; k++)
            past_samples[k] = '0;

        // Directed: reset history, full-scale extremes, clear with live history.
        queue_sample(0, 1'b0, 1'b0);
        queue_sample(OUT_MAX, 1'b0, 1'b0);
        queue_sample(OUT_MIN, 1'b0, 1'b0);
        queue_sample(12345, 1'b1, 1'b0);
        queue_sample(-1, 1'b0, 1'b0);
        queue_sample(1, 1'b0, 1'b0);

        // Find a two-sample record whose sum lands exactly on a rounding half.
        tie_found = 1'b0;
        tie_a     = 1;
        tie_b     = 0;
        for (a = 1; a <= 64 && !tie_found; a++) begin
            for (b = -32767; b <= 32767 && !tie_found; b++) begin
                if (((tap_coef[0] * b + tap_coef[1] * a) & ((64'sd1 <<< FRAC) - 1))
                        == (64'sd1 <<< (FRAC - 1))) begin
                    tie_a     = a;
                    tie_b     = b;
                    tie_found = 1'b1;
                end
            end
        end
        queue_sample(tie_a, 1'b1, 1'b0);
        queue_sample(tie_b, 1'b0, 1'b0);
        // negated pair: the tie falls on the other side of zero
        queue_sample(-tie_a, 1'b1, 1'b0);
        queue_sample(-tie_b, 1'b0, 1'b0);

        // Alternating full scale right after a clear.
        queue_sample(OUT_MIN, 1'b1, 1'b0);
        for (i = 0; i < 8; i++)
            queue_sample((i % 2) ? OUT_MIN : OUT_MAX, 1'b0, 1'b0);
        queue_sample(0, 1'b1, 1'b0);

        // Random records, most opened by a first-of-record mark (kind 9 runs on without one).
        produced   = 0;
        drain_done = 1'b0;
        while (produced < RANDOM_ITEMS) begin
            kind        = $urandom_range(0, 9);
            len         = $urandom_range(1, 100);
            amp         = $urandom_range(0, 32767);
            half_period = $urandom_range(1, 12);
            polarity    = $urandom_range(0, 1) ? 1 : -1;
            if (kind == 6 || kind == 7)
                len = $urandom_range(41, 90);
            for (i = 0; i < len; i++) begin
                case (kind)
                    4:       value = longint'($urandom_range(0, 64)) - 32;
                    5:       value = $urandom_range(0, 1) ? OUT_MAX : OUT_MIN;
                    6, 7:
                    begin
                        // sign pattern of the taps: lines up every 41 samples and clips
                        mag = $urandom_range(20000, 32767);
                        if (tap_coef[i % TAP_COUNT] > 0)
                            value = polarity * mag;
                        else if (tap_coef[i % TAP_COUNT] < 0)
                            value = -polarity * mag;
                        else
                            value = 0;
                    end
                    8:       value = ((i / half_period) % 2) ? amp : -amp;
                    default: value = longint'($signed(16'($urandom_range(0, 65535))));
                endcase
                if (i == 0)
                    first = (kind != 9);
                else
                    first = ($urandom_range(0, 49) == 0);
                // once, mid-run, let the pipeline run dry before the next record
                queue_sample(value, first,
                             (i == 0) && !drain_done && (produced >= RANDOM_ITEMS / 2));
                if (i == 0 && produced >= RANDOM_ITEMS / 2)
                    drain_done = 1'b1;
                produced++;
            end
        end
    end

    // Driver: offer the backlog in bursts with random gaps; hold while stalled.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            feed_valid <= 1'b0;
            feed       <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else begin
            if (feed_valid && !feed_stall)
                filtered_due.push_back(bandpass_predict(feed));
            if (!feed_valid || !feed_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    feed_valid <= 1'b0;
                end
                else if (sample_backlog.size() == 0) begin
                    feed_valid <= 1'b0;
                end
                else if (sample_backlog[0].drain_first && filtered_due.size() != 0) begin
                    // hold off until every outstanding result has come back
                    feed_valid <= 1'b0;
                end
                else begin
                    feed       <= sample_backlog[0].item;
                    feed_valid <= 1'b1;
                    void'(sample_backlog.pop_front());
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        // mix long unbroken streams with short choppy bursts
                        burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(100, 300)
                                                               : $urandom_range(1, 40);
                        gap_left   = $urandom_range(0, 3) == 0 ? $urandom_range(4, 16)
                                                               : $urandom_range(0, 3);
                    end
                end
            end
        end
    end

    // Receiver stall: segments of random modes, plus one long hold-off that fills
    // the block and backs up its input.
    stall_mode_t stall_mode    = STALL_NONE;
    int          segment_left  = 0;
    int          holdoff_left  = 0;
    int          stall_cycle   = 0;
    int          period_busy   = 1;
    int          period_free   = 1;
    int          period_phase  = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_stall <= 1'b0;
            stall_cycle  = 0;
            holdoff_left = 0;
            segment_left = 0;
        end
        else begin
            stall_cycle++;
            if (stall_cycle == HOLDOFF_START)
                holdoff_left = HOLDOFF_CYCLES;
            if (holdoff_left > 0) begin
                holdoff_left--;
                result_stall <= 1'b1;
            end
            else begin
                if (segment_left == 0) begin
                    stall_mode   = stall_mode_t'($urandom_range(0, 3));
                    segment_left = $urandom_range(20, 300);
                    period_busy  = $urandom_range(1, 6);
                    period_free  = $urandom_range(1, 6);
                    period_phase = 0;
                end
                segment_left--;
                case (stall_mode)
                    STALL_NONE:  result_stall <= 1'b0;
                    STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
                    default:
                    begin
                        result_stall <= (period_phase < period_busy);
                        period_phase = (period_phase + 1) % (period_busy + period_free);
                    end
                endcase
            end
        end
    end

    // Monitor: check each transfer on the result side against the oldest prediction.
    result_item_t oldest_due;

    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall) begin
            if (filtered_due.size() == 0) begin
                report_mismatch("unexpected result", longint'(result.filtered), 0);
            end
            else begin
                oldest_due = filtered_due.pop_front();
                if (result.filtered !== oldest_due.filtered)
                    report_mismatch("filtered", longint'(result.filtered),
                                    longint'(oldest_due.filtered));
                if (result.clipped !== oldest_due.clipped)
                    report_mismatch("clipped", longint'(result.clipped),
                                    longint'(oldest_due.clipped));
            end
            results_seen++;
        end
    end

    // End of run: wait for the backlog and the pipeline to drain, then judge.
    initial begin : run_end
        @(posedge rst_n);
        do
            @(posedge clk);
        while (sample_backlog.size() != 0 || feed_valid || filtered_due.size() != 0);
        repeat (DRAIN_SLACK) @(posedge clk);
        if (filtered_due.size() != 0)
            report_mismatch("missing results", 0, filtered_due.size());
        if (mismatch_count == 0)
            $display("[fixed_bandpass_fir_41] OK");
        else
            $display("[fixed_bandpass_fir_41] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/fbf41_pkg.sv
src/fbf41_cell.sv
src/fbf41_out.sv
src/fixed_bandpass_fir_41.sv
tb/sv/testbench.sv
